>>> hdl/lgarch_pkg.sv
// ----------------------------------------------------------------------------
// lgarch_pkg: shared types, constants and table builder
// Widths, register index codes, controller-to-datapath command bundle, and
// the elaboration-time builder for the ln(1+x) interpolation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgarch_pkg;

   localparam int DATA_W       = 32;
   localparam int MSB_W        = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int LG_FRAC_BITS = 16;
   localparam int LG_TABLE_DEPTH = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA_ZERO        = 3'd0,
      CSR_ALPHA_ONE         = 3'd1,
      CSR_ALPHA_TWO         = 3'd2,
      CSR_BETA_ONE          = 3'd3,
      CSR_INIT_LOG_VARIANCE = 3'd4
   } lgarch_csr_type;

   typedef enum logic [1:0] {
      MUL_SEL_H    = 2'd0,
      MUL_SEL_DIFF = 2'd1,
      MUL_SEL_A1   = 2'd2
   } lgarch_mul_sel_type;

   typedef struct packed {
      logic               accept;
      logic               norm_a;
      logic               norm_b;
      logic               pos;
      logic               rom;
      logic               ln_calc;
      logic               rnd;
      logic               commit;
      logic               mul_en;
      lgarch_mul_sel_type mul_sel;
   } lgarch_cmd_type;

   // shift-subtract divide, elaboration use only
   function automatic logic [63:0] lgarch_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      int          bit_idx;
      quo = '0;
      rem = '0;
      for (bit_idx = 63; bit_idx >= 0; bit_idx--) begin
         rem = {rem[62:0], num[bit_idx]};
         if (rem >= den) begin
            rem          = rem - den;
            quo[bit_idx] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln(1 + k/depth) in Q31, via 2*atanh(k/(2*depth+k)) series
   function automatic logic [31:0] lgarch_ln_entry(input int k, input int depth);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] t;
      logic [63:0] acc;
      int          term;
      z   = lgarch_udiv(64'(k) << 31, 64'(2 * depth + k));
      z2  = (z * z) >> 31;
      t   = z;
      acc = '0;
      for (term = 0; term < 100; term++) begin
         if (t != '0) begin
            acc = acc + lgarch_udiv(t, 64'(2 * term + 1));
            t   = (t * z2) >> 31;
         end
      end
      return 32'(acc << 1);
   endfunction

endpackage

>>> hdl/log_garch_variance_recursion.sv
// ----------------------------------------------------------------------------
// log_garch_variance_recursion: asymmetric log-GARCH(1,1) variance recursion
// Each request beat carries a return sample (signed fixed point, FRAC_BITS
// fraction bits), a leverage bit and a series start flag. The response beat
// returns the current log variance h (after an optional load from the
// init_log_variance register), a zero-sample flag and an overflow flag, and
// the block then replaces h by alpha_zero + alpha_one*ln(y^2) + beta_one*h
// + alpha_two*leverage, saturated to 32 bits. ln(y^2) comes from a leading-
// one normalize plus a linear-interpolated ln(1+x) table of LOG_TABLE_DEPTH
// segments; a zero sample floors it at the most negative value. One item is
// in flight at a time: the block takes a new one only after the last has
// passed its sum step. The single shared 33x33 multiplier serves beta_one*h,
// table interpolation and alpha_one*ln, beside a registered coarse/fine
// leading-one normalizer. The result sits in an output register, so the
// next item is accepted while it waits; if it is still unread when the next
// item finishes, that item holds in its last step. No clearing pass after
// reset.
// Config registers (index 0..4: alpha_zero, alpha_one, alpha_two, beta_one,
// init_log_variance) are always ready and are to be written only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_garch_variance_recursion #(
   parameter int FRAC_BITS       = lgarch_pkg::LG_FRAC_BITS,
   parameter int LOG_TABLE_DEPTH = lgarch_pkg::LG_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lgarch_pkg::DATA_W-1:0] req_sample,
   input  logic                                req_leverage_bit,
   input  logic                                req_series_start,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lgarch_pkg::DATA_W-1:0] rsp_log_variance,
   output logic                                rsp_zero_sample,
   output logic                                rsp_overflow,
   // config write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lgarch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic signed [lgarch_pkg::DATA_W-1:0] csr_data
);
   import lgarch_pkg::*;

   lgarch_cmd_type cmd;
   logic           csr_we;

   // config is never back-pressured
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // sequencer: stall/valid handshakes and per-step commands
   lgarch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: registers, state, multiplier, log table, result register
   lgarch_dpath #(
      .FRAC_BITS       (FRAC_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .req_leverage_bit (req_leverage_bit),
      .req_series_start (req_series_start),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_log_variance (rsp_log_variance),
      .rsp_zero_sample  (rsp_zero_sample),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

>>> hdl/lgarch_norm.sv
// ----------------------------------------------------------------------------
// lgarch_norm: registered coarse/fine leading-one normalizer
// Finds the MSB position of a nonzero magnitude and left-aligns the bits
// below it as a 32-bit fraction. Coarse shifts are registered first, then fine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgarch_norm (
   input  logic                         clock,
   input  logic                         step_a,
   input  logic                         step_b,
   input  logic [lgarch_pkg::DATA_W-1:0] mag,
   output logic [lgarch_pkg::DATA_W-1:0] frac,
   output logic [lgarch_pkg::MSB_W-1:0]  msb_pos
);
   import lgarch_pkg::*;

   localparam int Sh16 = DATA_W / 2;
   localparam int Sh8  = DATA_W / 4;
   localparam int Sh4  = DATA_W / 8;
   localparam int Sh2  = DATA_W / 16;

   logic [DATA_W-1:0] xa_ff, xa_in;
   logic [MSB_W-1:0]  lza_ff, lza_in;
   logic [DATA_W-1:0] frac_ff, frac_in;
   logic [MSB_W-1:0]  msb_ff, msb_in;
   logic [DATA_W-1:0] xb;
   logic [MSB_W-1:0]  lzb;

   // coarse: 16 / 8 / 4
   always_comb begin
      xa_in  = mag;
      lza_in = '0;
      if (xa_in[DATA_W-1 -: Sh16] == '0) begin
         xa_in  = xa_in << Sh16;
         lza_in = lza_in + MSB_W'(Sh16);
      end
      if (xa_in[DATA_W-1 -: Sh8] == '0) begin
         xa_in  = xa_in << Sh8;
         lza_in = lza_in + MSB_W'(Sh8);
      end
      if (xa_in[DATA_W-1 -: Sh4] == '0) begin
         xa_in  = xa_in << Sh4;
         lza_in = lza_in + MSB_W'(Sh4);
      end
   end

   // fine: 2 / 1, then drop the leading one
   always_comb begin
      xb  = xa_ff;
      lzb = lza_ff;
      if (xb[DATA_W-1 -: Sh2] == '0) begin
         xb  = xb << Sh2;
         lzb = lzb + MSB_W'(Sh2);
      end
      if (!xb[DATA_W-1]) begin
         xb  = xb << 1;
         lzb = lzb + MSB_W'(1);
      end
      frac_in = {xb[DATA_W-2:0], 1'b0};
      msb_in  = MSB_W'(DATA_W - 1) - lzb;
   end

   always_ff @(posedge clock) begin
      if (step_a) begin
         xa_ff  <= xa_in;
         lza_ff <= lza_in;
      end
      if (step_b) begin
         frac_ff <= frac_in;
         msb_ff  <= msb_in;
      end
   end

   assign frac    = frac_ff;
   assign msb_pos = msb_ff;

endmodule

>>> hdl/lgarch_dpath.sv
// ----------------------------------------------------------------------------
// lgarch_dpath: log-variance datapath
// Config registers, variance state, shared 33x33 multiplier, ln table
// interpolation, rounding, accumulation with saturation, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgarch_dpath #(
   parameter int FRAC_BITS       = lgarch_pkg::LG_FRAC_BITS,
   parameter int LOG_TABLE_DEPTH = lgarch_pkg::LG_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lgarch_pkg::lgarch_cmd_type          cmd,
   input  logic signed [lgarch_pkg::DATA_W-1:0] req_sample,
   input  logic                                req_leverage_bit,
   input  logic                                req_series_start,
   input  logic                                csr_we,
   input  logic [lgarch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic signed [lgarch_pkg::DATA_W-1:0] csr_data,
   output logic signed [lgarch_pkg::DATA_W-1:0] rsp_log_variance,
   output logic                                rsp_zero_sample,
   output logic                                rsp_overflow
);
   import lgarch_pkg::*;

   localparam int RomAw    = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int PosW     = DATA_W + RomAw;
   localparam int MulW     = DATA_W + 1;
   localparam int ProdW    = 2 * MulW;
   localparam int AccW     = ProdW - FRAC_BITS;
   localparam int LogW     = DATA_W + 8;              // p*ln2 plus headroom, doubled
   localparam int LogShift = DATA_W - 1 - FRAC_BITS;  // Q31 down to output format

   localparam logic [DATA_W-1:0] Ln2 = lgarch_ln_entry(LOG_TABLE_DEPTH, LOG_TABLE_DEPTH);
   localparam logic signed [LogW-1:0] LogOffset = $signed(LogW'(FRAC_BITS) * LogW'(Ln2));
   localparam logic signed [LogW-1:0] LogRound  = $signed(LogW'(1) << (LogShift - 1));
   localparam logic signed [ProdW-1:0] ProdRound = $signed(ProdW'(1) << (FRAC_BITS - 1));
   localparam logic signed [AccW-1:0] SatMax =
      $signed({{(AccW - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}});
   localparam logic signed [AccW-1:0] SatMin =
      $signed({{(AccW - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}});
   localparam logic [DATA_W-1:0] LnZero = {1'b1, {(DATA_W - 1){1'b0}}};

   // ln(1+k/D) table, Q31, entries 0..D
   logic [DATA_W-1:0] ln_rom [0:LOG_TABLE_DEPTH];
   for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [DATA_W-1:0] EntryVal = lgarch_ln_entry(gi, LOG_TABLE_DEPTH);
      assign ln_rom[gi] = EntryVal;
   end

   // config and state
   logic signed [DATA_W-1:0] alpha_zero_ff, alpha_one_ff, alpha_two_ff, beta_one_ff;
   logic signed [DATA_W-1:0] init_log_variance_ff;
   logic signed [DATA_W-1:0] h_ff, h_in;

   // working registers
   logic signed [DATA_W-1:0] sample_ff;
   logic                     lev_ff;
   logic                     zero_ff;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic signed [AccW-1:0]   term_h_ff, term_a_ff, partial_ff, partial_in;
   logic [RomAw-1:0]         k_ff, k_in, k_nxt;
   logic [DATA_W-1:0]        w_ff, w_in;
   logic signed [LogW-1:0]   plog_ff, plog_in, plog_raw;
   logic [DATA_W-1:0]        lo_ff, diff_ff, hi_val;
   logic [DATA_W-1:0]        lny2_ff, lny2_in;

   logic signed [DATA_W-1:0] rsp_h_ff;
   logic                     rsp_zero_ff, rsp_ovf_ff;

   logic [DATA_W-1:0]        mag;
   logic [DATA_W-1:0]        norm_frac;
   logic [MSB_W-1:0]         norm_msb;
   logic [PosW-1:0]          pos_full;
   logic signed [MulW-1:0]   op_a, op_b;
   logic signed [ProdW-1:0]  prod_rnd, prod_shr;
   logic signed [AccW-1:0]   prod_term;
   logic signed [AccW-1:0]   a0_ext, lev_ext, sum_acc;
   logic [DATA_W-1:0]        interp;
   logic signed [LogW-1:0]   log_sum, l31, l_rnd, l_shr;
   logic signed [DATA_W-1:0] h_sat;
   logic                     ovf;

   // config writes; unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_zero_ff        <= '0;
         alpha_one_ff         <= '0;
         alpha_two_ff         <= '0;
         beta_one_ff          <= '0;
         init_log_variance_ff <= '0;
      end else if (csr_we) begin
         unique case (lgarch_csr_type'(csr_index))
            CSR_ALPHA_ZERO:        alpha_zero_ff        <= csr_data;
            CSR_ALPHA_ONE:         alpha_one_ff         <= csr_data;
            CSR_ALPHA_TWO:         alpha_two_ff         <= csr_data;
            CSR_BETA_ONE:          beta_one_ff          <= csr_data;
            CSR_INIT_LOG_VARIANCE: init_log_variance_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // magnitude; -2^31 maps to 2^31 as unsigned
   assign mag = sample_ff[DATA_W-1] ? (~sample_ff + 1'b1) : sample_ff;

   lgarch_norm u_norm (
      .clock   (clock),
      .step_a  (cmd.norm_a),
      .step_b  (cmd.norm_b),
      .mag     (mag),
      .frac    (norm_frac),
      .msb_pos (norm_msb)
   );

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_SEL_H: begin
            op_a = {beta_one_ff[DATA_W-1], beta_one_ff};
            op_b = {h_ff[DATA_W-1], h_ff};
         end
         MUL_SEL_DIFF: begin
            op_a = {1'b0, diff_ff};
            op_b = {1'b0, w_ff};
         end
         MUL_SEL_A1: begin
            op_a = {alpha_one_ff[DATA_W-1], alpha_one_ff};
            op_b = {lny2_ff[DATA_W-1], lny2_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = ProdW'(op_a) * ProdW'(op_b);
   end

   // round half up to output format
   always_comb begin
      prod_rnd  = prod_ff + ProdRound;
      prod_shr  = prod_rnd >>> FRAC_BITS;
      prod_term = prod_shr[AccW-1:0];
   end

   // table position and per-exponent log
   always_comb begin
      pos_full = PosW'(norm_frac) * PosW'(LOG_TABLE_DEPTH);
      k_in     = pos_full[PosW-1:DATA_W];
      w_in     = pos_full[DATA_W-1:0];
      plog_raw = LogW'(norm_msb) * LogW'(Ln2);
      plog_in  = plog_raw - LogOffset;
      a0_ext   = AccW'(alpha_zero_ff);
      lev_ext  = lev_ff ? AccW'(alpha_two_ff) : AccW'(1'b0);
      partial_in = a0_ext + term_h_ff + lev_ext;
   end

   assign k_nxt  = k_ff + 1'b1;
   assign hi_val = ln_rom[k_nxt];

   // ln(y^2): interpolate, add exponent part, double, round
   always_comb begin
      interp  = lo_ff + prod_ff[2*DATA_W-1:DATA_W];
      log_sum = plog_ff + $signed(LogW'(interp));
      l31     = log_sum <<< 1;
      l_rnd   = l31 + LogRound;
      l_shr   = l_rnd >>> LogShift;
      lny2_in = zero_ff ? LnZero : l_shr[DATA_W-1:0];
   end

   // final sum and clamp
   always_comb begin
      sum_acc = partial_ff + term_a_ff;
      ovf     = 1'b0;
      if (sum_acc > SatMax) begin
         h_sat = SatMax[DATA_W-1:0];
         ovf   = 1'b1;
      end else if (sum_acc < SatMin) begin
         h_sat = SatMin[DATA_W-1:0];
         ovf   = 1'b1;
      end else begin
         h_sat = sum_acc[DATA_W-1:0];
      end
   end

   always_comb begin
      h_in = h_ff;
      if (cmd.accept && req_series_start)
         h_in = init_log_variance_ff;
      else if (cmd.commit)
         h_in = h_sat;
   end

   always_ff @(posedge clock) begin
      if (reset)
         h_ff <= '0;
      else
         h_ff <= h_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         lev_ff    <= req_leverage_bit;
      end
      if (cmd.norm_a)
         zero_ff <= (sample_ff == '0);
      if (cmd.mul_en)
         prod_ff <= prod_in;
      if (cmd.norm_b)
         term_h_ff <= prod_term;
      if (cmd.pos) begin
         k_ff       <= k_in;
         w_ff       <= w_in;
         plog_ff    <= plog_in;
         partial_ff <= partial_in;
      end
      if (cmd.rom) begin
         lo_ff   <= ln_rom[k_ff];
         diff_ff <= hi_val - ln_rom[k_ff];
      end
      if (cmd.ln_calc)
         lny2_ff <= lny2_in;
      if (cmd.rnd)
         term_a_ff <= prod_term;
      if (cmd.commit) begin
         rsp_h_ff    <= h_ff;
         rsp_zero_ff <= zero_ff;
         rsp_ovf_ff  <= ovf;
      end
   end

   assign rsp_log_variance = rsp_h_ff;
   assign rsp_zero_sample  = rsp_zero_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // overflow flag must come with a clamped state
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (!rsp_ovf_ff || h_ff == SatMax[DATA_W-1:0]
                      || h_ff == SatMin[DATA_W-1:0]))
      else $error("overflow flagged but state not at a limit");

   // a zero sample always leaves the log at its floor
   a_zero_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && zero_ff |-> lny2_ff == LnZero)
      else $error("zero sample without saturated log");

endmodule

>>> hdl/lgarch_ctrl.sv
// ----------------------------------------------------------------------------
// lgarch_ctrl: sequencing state machine
// Steps one item through normalize, table, interpolate, multiply and sum,
// and owns the input stall and the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgarch_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lgarch_pkg::lgarch_cmd_type cmd
);
   import lgarch_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_NORM_A = 10'b00_0000_0010,
      ST_NORM_B = 10'b00_0000_0100,
      ST_POS    = 10'b00_0000_1000,
      ST_ROM    = 10'b00_0001_0000,
      ST_INTERP = 10'b00_0010_0000,
      ST_LN     = 10'b00_0100_0000,
      ST_MUL_A  = 10'b00_1000_0000,
      ST_RND    = 10'b01_0000_0000,
      ST_SUM    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_SEL_H;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid)
               state_in = ST_NORM_A;
         end
         ST_NORM_A: begin
            cmd.norm_a  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_H;
            state_in    = ST_NORM_B;
         end
         ST_NORM_B: begin
            cmd.norm_b = 1'b1;
            state_in   = ST_POS;
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_ROM;
         end
         ST_ROM: begin
            cmd.rom  = 1'b1;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_DIFF;
            state_in    = ST_LN;
         end
         ST_LN: begin
            cmd.ln_calc = 1'b1;
            state_in    = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_A1;
            state_in    = ST_RND;
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.commit = out_free;
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit)
         rsp_valid_in = 1'b1;
      else
         rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_NORM_A)
      else $error("accepted beat did not start processing");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise result valid");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SUM))
      else $error("result valid rose outside the sum step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.commit)
      else $error("held result overwritten");

endmodule

>>> dv/log_garch_variance_recursion_tb.sv
// ----------------------------------------------------------------------------
// log_garch_variance_recursion_tb: self-checking bench for the log-GARCH block
// A queue of return samples feeds a clocked driver on the req_ channel, and a
// clocked monitor on the rsp_ channel checks every result beat against a
// bit-true Q16.16 predictor of the variance recursion. The run walks through
// coefficient sets (typical, spread, all-max, all-min, symmetric) and through
// phases of sender idling, receiver stalling, both, and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_garch_variance_recursion_tb;
   import lgarch_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 16;      // a bit more than one item's pass through the block
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLDOFF_PHASE  = 1;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_CSR = 3'd7;   // no register here

   localparam longint SAT_HIGH = 64'sh7FFF_FFFF;
   localparam longint SAT_LOW  = -64'sh8000_0000;

   typedef enum int {
      CFG_TYPICAL,
      CFG_SPREAD,
      CFG_ALL_MAX,
      CFG_ALL_MIN,
      CFG_SYMMETRIC
   } cfg_plan_type;

   // one observation as it travels on the request channel
   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     leverage_bit;
      logic                     series_start;
   } return_obs_type;

   // one result beat as it should appear on the response channel
   typedef struct packed {
      logic signed [DATA_W-1:0] log_variance;
      logic                     zero_sample;
      logic                     overflow;
   } lv_beat_type;

   // Phase plan: coefficient set, idling on each side, random observations.
   // Phase 0 carries the directed observations instead of random ones.
   localparam int NUM_PHASES = 7;
   localparam cfg_plan_type PLAN_CFG [NUM_PHASES] = '{
      CFG_TYPICAL, CFG_TYPICAL, CFG_SPREAD, CFG_ALL_MAX, CFG_ALL_MIN,
      CFG_SYMMETRIC, CFG_SPREAD
   };
   localparam int PLAN_SEND_IDLE [NUM_PHASES] = '{0, 0, 80, 0, 23, 23, 0};
   localparam int PLAN_RECV_STALL [NUM_PHASES] = '{0, 0, 0, 80, 23, 23, 0};
   localparam int PLAN_ITEMS [NUM_PHASES] = '{0, 400, 300, 150, 150, 300, 300};

   // Directed observations: field extremes, zero sample, most negative sample,
   // first item straight out of reset, series restarts, top table segment.
   localparam int DIRECTED_COUNT = 14;
   localparam logic signed [DATA_W-1:0] DIRECTED_SAMPLE [DIRECTED_COUNT] = '{
      32'sh0001_0000,   // 1.0: ln is zero, h still at its reset value
      32'sh0000_0000,   // zero sample with a series start
      32'sh0000_0001,   // smallest magnitude
      -32'sh0000_0001,
      32'sh7FFF_FFFF,   // largest positive
      32'sh8000_0000,   // most negative, magnitude is exactly 2^31
      -32'sh0001_0000,  // restart in mid series
      32'sh0001_FFFF,   // fraction just under one: last table segment
      32'sh0001_0400,
      32'sh4000_0000,
      32'sh0000_0000,   // zero again, with leverage and a restart
      32'sh0000_028F,   // about 0.01
      -32'sh0000_199A,
      32'sh0001_8000
   };
   localparam logic [DIRECTED_COUNT-1:0] DIRECTED_LEV   = 14'b01010101101100;
   localparam logic [DIRECTED_COUNT-1:0] DIRECTED_START = 14'b00010001000010;

   // ------------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic                     req_leverage_bit = 1'b0;
   logic                     req_series_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_log_variance;
   logic                     rsp_zero_sample;
   logic                     rsp_overflow;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic signed [DATA_W-1:0] csr_data = '0;

   log_garch_variance_recursion DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_leverage_bit (req_leverage_bit),
      .req_series_start (req_series_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_log_variance (rsp_log_variance),
      .rsp_zero_sample  (rsp_zero_sample),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: coefficient copy, log variance h, ln(1+x) table in Q31
   // ------------------------------------------------------------------------
   longint          coef [CSR_INIT_LOG_VARIANCE + 1];
   longint          model_h;
   longint unsigned ln_q31 [LG_TABLE_DEPTH + 1];

   return_obs_type  obs_pending [$];   // waiting to be offered
   lv_beat_type     lv_expected [$];   // predicted, not yet seen on rsp_

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int beats_accepted  = 0;
   int results_seen    = 0;
   int zero_seen       = 0;
   int overflow_seen   = 0;
   int error_count     = 0;
   int holdoff_target  = 0;   // raised by the sequencer only
   int holdoff_count   = 0;   // advanced by the hold-off counter only
   logic holdoff_active;

   assign holdoff_active = (holdoff_count < holdoff_target);

   // floor(x / 2^shift) after adding half an LSB: round half up
   function automatic longint round_half_up(input longint x, input int shift);
      return (x + (longint'(1) <<< (shift - 1))) >>> shift;
   endfunction

   // ln(m^2) with LG_FRAC_BITS fraction bits for a nonzero magnitude m.
   // Leading-one normalize, then linear interpolation between table entries.
   function automatic longint ln_square_q16(input longint unsigned mag);
      int              msb;
      int              i;
      longint unsigned frac;
      longint unsigned pos;
      longint unsigned seg;
      longint unsigned w;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned interp;
      longint          ln2;
      longint          l31;
      msb = 0;
      for (i = 0; i < 33; i++)
         if (mag[i]) msb = i;
      frac = ((mag - (64'd1 << msb)) << (32 - msb)) & 64'hFFFF_FFFF;
      pos  = frac * LG_TABLE_DEPTH;
      seg  = pos >> 32;
      w    = pos & 64'hFFFF_FFFF;
      if (seg >= LG_TABLE_DEPTH) seg = LG_TABLE_DEPTH - 1;
      lo     = ln_q31[seg];
      hi     = ln_q31[seg + 1];
      interp = lo + (((hi - lo) * w) >> 32);
      ln2    = longint'(ln_q31[LG_TABLE_DEPTH]);   // top entry is ln(2)
      l31    = 2 * (longint'(msb) * ln2 + longint'(interp)) - 2 * LG_FRAC_BITS * ln2;
      return round_half_up(l31, 31 - LG_FRAC_BITS);
   endfunction

   // Emit h (after any series-start load), then advance it by the recursion
   function automatic lv_beat_type garch_advance(input return_obs_type obs);
      lv_beat_type beat;
      longint      ln_y2;
      longint      next_h;
      longint      y;
      if (obs.series_start) model_h = coef[CSR_INIT_LOG_VARIANCE];
      y                 = longint'($signed(obs.sample));
      beat.log_variance = model_h[DATA_W-1:0];
      beat.zero_sample  = (y == 0);
      if (beat.zero_sample) ln_y2 = -(longint'(1) <<< 31);
      else ln_y2 = ln_square_q16((y < 0) ? -y : y);
      next_h = coef[CSR_ALPHA_ZERO]
             + round_half_up(coef[CSR_ALPHA_ONE] * ln_y2, LG_FRAC_BITS)
             + round_half_up(coef[CSR_BETA_ONE] * model_h, LG_FRAC_BITS)
             + (obs.leverage_bit ? coef[CSR_ALPHA_TWO] : 64'sd0);
      beat.overflow = (next_h > SAT_HIGH) || (next_h < SAT_LOW);
      if (next_h > SAT_HIGH) next_h = SAT_HIGH;
      if (next_h < SAT_LOW) next_h = SAT_LOW;
      model_h = next_h;
      return beat;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   // Sample mix: zeros, edge values, full-range words, and log-uniform
   // magnitudes so every exponent of the normalizer gets exercised.
   function automatic logic signed [DATA_W-1:0] pick_sample();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(9))
         0: v = '0;
         1: begin
            case ($urandom_range(5))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0000_0001;
               3: v = -32'sh0000_0001;
               4: v = 32'sh0001_0000;
               default: v = -32'sh0001_0000;
            endcase
         end
         2, 3: v = $urandom;
         default: begin
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   // coefficient drawn from the extremes, zero, full range or about +/-1.0
   function automatic logic signed [DATA_W-1:0] pick_coef();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return $urandom;
         default: return $signed($urandom_range(131071)) - 32'sd65536;
      endcase
   endfunction

   // Random observations grouped into series. Each series opens with a start
   // flag; leverage mostly follows the sign of the return, as in use. A few
   // stray restarts and random leverage bits act as noise.
   task automatic queue_random_series(input int count);
      int             i;
      int             left_in_series;
      return_obs_type obs;
      left_in_series = 0;
      for (i = 0; i < count; i++) begin
         obs.sample = pick_sample();
         if ($urandom_range(3) != 0) obs.leverage_bit = obs.sample[DATA_W-1];
         else obs.leverage_bit = 1'($urandom_range(1));
         if (left_in_series == 0) begin
            obs.series_start = 1'b1;
            left_in_series   = $urandom_range(40, 1);
         end else begin
            obs.series_start = ($urandom_range(31) == 0);
         end
         left_in_series--;
         obs_pending.push_back(obs);
      end
   endtask

   // One config beat; called at a rising edge, returns at the handshake edge
   // with csr_valid still high so back-to-back writes need no extra toggle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_INIT_LOG_VARIANCE) coef[idx] = longint'(value);
   endtask

   task automatic load_coefficients(input cfg_plan_type plan);
      logic signed [DATA_W-1:0] a0;
      logic signed [DATA_W-1:0] a1;
      logic signed [DATA_W-1:0] a2;
      logic signed [DATA_W-1:0] b1;
      logic signed [DATA_W-1:0] h0;
      case (plan)
         CFG_TYPICAL: begin
            a0 = -32'sd32768;    // -0.5
            a1 = 32'sd6554;      // 0.1
            a2 = 32'sd3277;      // 0.05
            b1 = 32'sd58982;     // 0.9
            h0 = -32'sd262144;   // -4.0
         end
         CFG_ALL_MAX: begin
            a0 = 32'sh7FFF_FFFF; a1 = a0; a2 = a0; b1 = a0; h0 = a0;
         end
         CFG_ALL_MIN: begin
            a0 = 32'sh8000_0000; a1 = a0; a2 = a0; b1 = a0; h0 = a0;
         end
         CFG_SYMMETRIC: begin
            a0 = $signed($urandom_range(131071)) - 32'sd65536;
            a1 = $signed($urandom_range(32768));
            a2 = '0;
            b1 = $signed($urandom_range(65535));
            h0 = $signed($urandom_range(1048575)) - 32'sd524288;
         end
         default: begin
            a0 = pick_coef(); a1 = pick_coef(); a2 = pick_coef();
            b1 = pick_coef(); h0 = pick_coef();
         end
      endcase
      write_csr(CSR_ALPHA_ZERO, a0);
      write_csr(CSR_ALPHA_ONE, a1);
      write_csr(CSR_ALPHA_TWO, a2);
      write_csr(CSR_BETA_ONE, b1);
      write_csr(CSR_INIT_LOG_VARIANCE, h0);
      write_csr(UNMAPPED_CSR, $urandom);   // must be dropped by the block
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. The payload only moves when the bus is empty or the
   // current beat was just taken; valid is a coin flip, never a function of
   // req_stall. The accepted beat is predicted here, in acceptance order.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_samples
      return_obs_type on_bus;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            lv_expected.push_back(garch_advance(on_bus));
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (obs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus            = obs_pending.pop_front();
               req_sample       <= on_bus.sample;
               req_leverage_bit <= on_bus.leverage_bit;
               req_series_start <= on_bus.series_start;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // hold-off counter: runs while the target is ahead of the count
   always @(posedge clock) begin
      if (holdoff_active) holdoff_count <= holdoff_count + 1;
   end

   // receiver back-pressure: hold-off window or random stall
   always @(posedge clock) begin
      rsp_stall <= holdoff_active || ($urandom_range(99) < recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Response monitor: each taken beat against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      lv_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lv_expected.size() == 0) begin
            note_error($sformatf("result beat with nothing expected: lv=%h zero=%b ovf=%b",
                                 rsp_log_variance, rsp_zero_sample, rsp_overflow));
         end else begin
            want = lv_expected.pop_front();
            results_seen++;
            if (want.zero_sample) zero_seen++;
            if (want.overflow) overflow_seen++;
            if (rsp_log_variance !== want.log_variance ||
                rsp_zero_sample !== want.zero_sample ||
                rsp_overflow !== want.overflow)
               note_error($sformatf({"beat %0d: lv exp %h got %h, zero exp %b got %b, ",
                                     "ovf exp %b got %b"}, results_seen,
                                    want.log_variance, rsp_log_variance,
                                    want.zero_sample, rsp_zero_sample,
                                    want.overflow, rsp_overflow));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: reset, then per phase load coefficients while idle, queue the
   // observations and wait for every predicted beat to drain.
   // ------------------------------------------------------------------------
   initial begin : sequencer
      int              k;
      int              p;
      int              i;
      int              mark;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      longint unsigned acc;
      longint unsigned n;
      return_obs_type  obs;

      // ln(1 + k/D) in Q31 from the 2*atanh(k/(2D+k)) series
      for (k = 0; k <= LG_TABLE_DEPTH; k++) begin
         z   = (64'(k) << 31) / 64'(2 * LG_TABLE_DEPTH + k);
         z2  = (z * z) >> 31;
         t   = z;
         acc = 0;
         n   = 1;
         while (t != 0 && n < 200) begin
            acc += t / n;
            t    = (t * z2) >> 31;
            n   += 2;
         end
         ln_q31[k] = (2 * acc) & 64'hFFFF_FFFF;
      end
      foreach (coef[r]) coef[r] = 0;
      model_h = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = PLAN_SEND_IDLE[p];
         recv_stall_pct = PLAN_RECV_STALL[p];
         load_coefficients(PLAN_CFG[p]);
         if (p == 0) begin
            for (i = 0; i < DIRECTED_COUNT; i++) begin
               obs.sample       = DIRECTED_SAMPLE[i];
               obs.leverage_bit = DIRECTED_LEV[i];
               obs.series_start = DIRECTED_START[i];
               obs_pending.push_back(obs);
            end
         end else begin
            queue_random_series(PLAN_ITEMS[p]);
         end
         // Long receiver hold-off with the sender still pushing: the output
         // register and the item in flight fill up and req_stall must rise.
         if (p == HOLDOFF_PHASE) begin
            mark = beats_accepted + 40;
            while (beats_accepted < mark) @(posedge clock);
            holdoff_target <= holdoff_target + HOLDOFF_CYCLES;
         end
         while (obs_pending.size() != 0 || req_valid || lv_expected.size() != 0)
            @(posedge clock);
         // every item yields a beat, but let the state update settle anyway
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      $display("Covered %0d sample beats over %0d coefficient/back-pressure phases,",
               results_seen, NUM_PHASES);
      $display("including %0d zero samples and %0d saturated updates.",
               zero_seen, overflow_seen);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("Mismatches: %0d", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d beats still expected", lv_expected.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
hdl/lgarch_pkg.sv
hdl/lgarch_norm.sv
hdl/lgarch_dpath.sv
hdl/lgarch_ctrl.sv
hdl/log_garch_variance_recursion.sv
dv/log_garch_variance_recursion_tb.sv
